@@ design/dtp_pkg.sv @@
package dtp_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_DIGIT = 2'd1,
        ST_BAD_TERM = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TOKEN = 2'd1
    } t_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned MAG_W   = 31;
    localparam int unsigned CNT_W   = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

@@ design/dtp_if.sv @@
interface dtp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface dtp_res_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  value;
    dtp_pkg::t_status    status;
    logic [7:0]          consumed;

    modport source (output valid, output value, output status, output consumed, input ready);
    modport sink   (input valid, input value, input status, input consumed, output ready);
endinterface

@@ design/decimal_integer_token_parser_unit.sv @@
// Channel  | Direction | Beat payload
// ---------+-----------+-------------------------------------------
// i_char   | in        | char_code[7:0]
// o_res    | out       | value[31:0] signed, status[1:0], consumed[7:0]
//
// One character is taken every cycle unless a terminator is stalled; the parse step (multiply by ten, add,
// range check) sits between the input register and the result register.
// A terminating character passes through the input register, then the result register, onto o_res.
// Reset clears the parse state and both valid flags.
// A waiting result stalls only a following terminator; digits and leading signs
// keep flowing while o_res is held.
module decimal_integer_token_parser_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dtp_char_if.sink              i_char,
    dtp_res_if.source             o_res
);

    logic [7:0]                   r_char;
    logic                         r_in_vld;

    dtp_pkg::t_phase              r_phase, n_phase;
    logic                         r_neg, n_neg;
    logic [dtp_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic                         r_ovf, n_ovf;
    logic                         r_seen, n_seen;
    logic [dtp_pkg::CNT_W-1:0]    r_cnt, n_cnt;

    logic                         r_out_vld;
    logic signed [31:0]           r_out_value, n_out_value;
    dtp_pkg::t_status             r_out_status, n_out_status;
    logic [7:0]                   r_out_cnt;

    logic                         in_token, is_digit, is_sign, is_term, is_end;
    logic                         adv, emit;
    logic [3:0]                   digit;
    logic [dtp_pkg::MAG_W+3:0]    mag_next;
    logic                         mag_over;
    logic [dtp_pkg::CNT_W-1:0]    cnt_inc;

    assign in_token = (r_phase == dtp_pkg::PH_TOKEN);
    assign is_digit = (r_char >= dtp_pkg::CH_ZERO) && (r_char <= dtp_pkg::CH_NINE);
    assign is_sign  = (r_char == dtp_pkg::CH_MINUS) || (r_char == dtp_pkg::CH_PLUS);
    assign is_term  = !is_digit && !(!in_token && is_sign);
    assign is_end   = (r_char == dtp_pkg::CH_NUL) || (r_char == dtp_pkg::CH_SPACE);

    // A terminator may only advance when the result register is free or draining.
    assign adv  = r_in_vld && (!is_term || !r_out_vld || o_res.ready);
    assign emit = adv && is_term;

    assign i_char.ready = !r_in_vld || adv;

    assign digit    = 4'(r_char - dtp_pkg::CH_ZERO);
    assign mag_next = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                    + {{(dtp_pkg::MAG_W){1'b0}}, digit};
    assign mag_over = |mag_next[dtp_pkg::MAG_W+3:dtp_pkg::MAG_W];
    assign cnt_inc  = (r_cnt == dtp_pkg::CNT_MAX) ? r_cnt
                    : r_cnt + {{(dtp_pkg::CNT_W-1){1'b0}}, 1'b1};

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (adv) begin
            n_phase = is_term ? dtp_pkg::PH_START : dtp_pkg::PH_TOKEN;
        end
    end

    // Token state and result.
    always_comb begin
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_ovf  = r_ovf;
        n_seen = r_seen;
        n_cnt  = r_cnt;

        if (!r_seen) begin
            n_out_status = dtp_pkg::ST_NO_DIGIT;
        end else if (r_ovf) begin
            n_out_status = dtp_pkg::ST_OVERFLOW;
        end else if (is_end) begin
            n_out_status = dtp_pkg::ST_OK;
        end else begin
            n_out_status = dtp_pkg::ST_BAD_TERM;
        end

        if (n_out_status != dtp_pkg::ST_OK) begin
            n_out_value = '0;
        end else if (r_neg) begin
            n_out_value = -$signed({1'b0, r_mag});
        end else begin
            n_out_value = $signed({1'b0, r_mag});
        end

        if (adv) begin
            if (is_digit) begin
                if (!r_ovf) begin
                    if (mag_over) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_mag = mag_next[dtp_pkg::MAG_W-1:0];
                    end
                end
                n_seen = 1'b1;
                n_cnt  = cnt_inc;
            end else if (!is_term) begin
                n_neg = (r_char == dtp_pkg::CH_MINUS);
                n_cnt = cnt_inc;
            end else begin
                n_neg  = 1'b0;
                n_mag  = '0;
                n_ovf  = 1'b0;
                n_seen = 1'b0;
                n_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= dtp_pkg::PH_START;
            r_neg     <= 1'b0;
            r_mag     <= '0;
            r_ovf     <= 1'b0;
            r_seen    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_char.ready) begin
                r_in_vld <= i_char.valid;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_ovf   <= n_ovf;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_code;
        end
        if (emit) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_cnt    <= r_cnt;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.value    = r_out_value;
    assign o_res.status   = r_out_status;
    assign o_res.consumed = r_out_cnt;

endmodule

@@ tb/decimal_integer_token_parser_unit_test.sv @@
module decimal_integer_token_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int TAIL_CHARS    = 250;
    localparam int STREAM_CHARS  = 1600;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 20;

    typedef struct packed {
        logic signed [31:0] value;
        dtp_pkg::t_status   status;
        logic [7:0]         consumed;
    } t_token_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dtp_char_if char_bus ();
    dtp_res_if  res_bus ();

    decimal_integer_token_parser_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_res   (res_bus)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0]    pending_chars[$];
    t_token_result pending_results[$];

    // Shadow copy of the parse state.
    dtp_pkg::t_phase tok_phase = dtp_pkg::PH_START;
    bit          tok_negative = 1'b0;
    logic [30:0] tok_magnitude = '0;
    bit          tok_overflowed = 1'b0;
    bit          tok_seen_digit = 1'b0;
    logic [7:0]  tok_count = '0;

    int fail_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int src_gap = 0;
    int sink_wait = 0;
    bit hold_done = 1'b0;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= dtp_pkg::CH_ZERO && c <= dtp_pkg::CH_NINE;
    endfunction

    function automatic void clear_token();
        tok_phase      = dtp_pkg::PH_START;
        tok_negative   = 1'b0;
        tok_magnitude  = '0;
        tok_overflowed = 1'b0;
        tok_seen_digit = 1'b0;
        tok_count      = '0;
    endfunction

    function automatic void bump_count();
        if (tok_count != dtp_pkg::CNT_MAX)
            tok_count = tok_count + 8'd1;
    endfunction

    // Advances the shadow state by one character; a terminator queues its result.
    function automatic void parse_char(input logic [7:0] c);
        logic [34:0]   next_mag;
        t_token_result r;
        if (is_digit(c)) begin
            if (!tok_overflowed) begin
                next_mag = {4'b0, tok_magnitude} * 35'd10 + 35'(c - dtp_pkg::CH_ZERO);
                if (next_mag > 35'h7FFF_FFFF)
                    tok_overflowed = 1'b1;
                else
                    tok_magnitude = next_mag[30:0];
            end
            tok_seen_digit = 1'b1;
            bump_count();
            tok_phase = dtp_pkg::PH_TOKEN;
        end else if (tok_phase != dtp_pkg::PH_TOKEN
                     && (c == dtp_pkg::CH_MINUS || c == dtp_pkg::CH_PLUS)) begin
            tok_negative = (c == dtp_pkg::CH_MINUS);
            bump_count();
            tok_phase = dtp_pkg::PH_TOKEN;
        end else begin
            if (!tok_seen_digit)
                r.status = dtp_pkg::ST_NO_DIGIT;
            else if (tok_overflowed)
                r.status = dtp_pkg::ST_OVERFLOW;
            else if (c == dtp_pkg::CH_NUL || c == dtp_pkg::CH_SPACE)
                r.status = dtp_pkg::ST_OK;
            else
                r.status = dtp_pkg::ST_BAD_TERM;
            r.value = '0;
            if (r.status == dtp_pkg::ST_OK)
                r.value = tok_negative ? -$signed({1'b0, tok_magnitude})
                                       : $signed({1'b0, tok_magnitude});
            r.consumed = tok_count;
            pending_results.push_back(r);
            clear_token();
        end
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back(s[i]);
    endfunction

    function automatic void push_digits(input int unsigned n);
        repeat (n) pending_chars.push_back(8'(dtp_pkg::CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] random_non_digit();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (is_digit(b))
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Mostly well-formed tokens with random content, plus noise and broken tokens.
    function automatic void add_random_token();
        int unsigned kind;
        int unsigned pick;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 4)) pending_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 3))
            0: pending_chars.push_back(dtp_pkg::CH_MINUS);
            1: pending_chars.push_back(dtp_pkg::CH_PLUS);
            default: ;
        endcase
        if (kind < 22)
            push_text($sformatf("%0d", 32'd2147483645 + 32'($urandom_range(0, 5))));
        else if (kind < 30)
            push_digits($urandom_range(11, 13));
        else if (kind >= 34)
            push_digits($urandom_range(1, 10));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            pending_chars.push_back(dtp_pkg::CH_NUL);
        else if (pick < 8)
            pending_chars.push_back(dtp_pkg::CH_SPACE);
        else
            pending_chars.push_back(random_non_digit());
    endfunction

    task automatic check_result();
        t_token_result exp_r;
        results_seen++;
        if (pending_results.size() == 0) begin
            $error("result beat with no expectation: value %0d status %0d consumed %0d",
                   res_bus.value, res_bus.status, res_bus.consumed);
            fail_count++;
        end else begin
            exp_r = pending_results.pop_front();
            if (res_bus.value !== exp_r.value) begin
                $error("value: expected %0d, got %0d", exp_r.value, res_bus.value);
                fail_count++;
            end
            if (res_bus.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, res_bus.status);
                fail_count++;
            end
            if (res_bus.consumed !== exp_r.consumed) begin
                $error("consumed: expected %0d, got %0d", exp_r.consumed, res_bus.consumed);
                fail_count++;
            end
        end
    endtask

    // Character driver. A new beat is loaded only when the slot is empty or
    // the current beat is being taken at this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_bus.valid <= 1'b0;
            src_gap = 0;
        end else if (!char_bus.valid || char_bus.ready) begin
            if (char_bus.valid)
                parse_char(char_bus.char_code);
            if (src_gap != 0) begin
                src_gap--;
                char_bus.valid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
                char_bus.valid     <= 1'b1;
                char_bus.char_code <= pending_chars.pop_front();
                if (pending_chars.size() >= TAIL_CHARS && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 13);
            end else begin
                char_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure and one long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (res_bus.valid && res_bus.ready)
                check_result();
            if (sink_wait != 0) begin
                sink_wait--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
                if (!hold_done && results_seen >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    sink_wait = HOLD_CYCLES;
                end else if (pending_chars.size() >= TAIL_CHARS
                             && $urandom_range(0, 7) == 0) begin
                    sink_wait = $urandom_range(1, 13);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        bit long_done;
        long_done = 1'b0;

        push_text("2147483647");
        pending_chars.push_back(dtp_pkg::CH_SPACE);
        // The most negative 32-bit value is out of range as a magnitude.
        push_text("-2147483648");
        pending_chars.push_back(dtp_pkg::CH_NUL);
        pending_chars.push_back(dtp_pkg::CH_NUL);
        push_text("+-");
        push_text("7");
        pending_chars.push_back(8'hFF);
        push_text("-0+");

        while (pending_chars.size() < STREAM_CHARS) begin
            if (!long_done && pending_chars.size() > 800) begin
                long_done = 1'b1;
                // The count saturates on both of these; leading zeros keep the first in range.
                repeat (262) pending_chars.push_back(dtp_pkg::CH_ZERO);
                push_text("5 ");
                push_digits(258);
                pending_chars.push_back(dtp_pkg::CH_NUL);
            end
            add_random_token();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || char_bus.valid)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
